@@ src/all_pole_recursive_filter_assert.svh @@
// Assertion macros used by the checker file of the filter.
// Each macro takes a label, an antecedent, a consequent and the message to report.
`ifndef ALL_POLE_RECURSIVE_FILTER_ASSERT_SVH
`define ALL_POLE_RECURSIVE_FILTER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define APF_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define APF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/apf_pkg.sv @@
package apf_pkg;

    localparam int MAX_ORDER   = 6;
    localparam int SAMPLE_BITS = 16;
    localparam int COEF_BITS   = 16;
    localparam int OUT_BITS    = 24;
    localparam int FRAC_BITS   = 14;
    localparam int ORDER_BITS  = 3;
    localparam int PROD_BITS   = COEF_BITS + OUT_BITS;
    // Six products plus the scaled sample fit with three guard bits.
    localparam int ACC_BITS    = PROD_BITS + 3;
    localparam int PADDR_BITS  = 5;
    localparam int PDATA_BITS  = 32;
    localparam int REG_IDX_BITS = 3;

    typedef logic [REG_IDX_BITS-1:0] reg_idx_t;

    localparam reg_idx_t REG_FILTER_ORDER = 3'd0;
    localparam reg_idx_t REG_TAP_COEF_0   = 3'd1;
    localparam reg_idx_t REG_TAP_COEF_5   = 3'd6;

    typedef logic [MAX_ORDER-1:0][OUT_BITS-1:0]  hist_t;
    typedef logic [MAX_ORDER-1:0][COEF_BITS-1:0] coef_arr_t;

    typedef struct packed {
        logic [ORDER_BITS-1:0] order;
        coef_arr_t             coef;
    } cfg_t;

    localparam logic [OUT_BITS-1:0] OUT_MAX_VAL = {1'b0, {(OUT_BITS-1){1'b1}}};
    localparam logic [OUT_BITS-1:0] OUT_MIN_VAL = {1'b1, {(OUT_BITS-1){1'b0}}};

endpackage

@@ src/all_pole_recursive_filter.sv @@
// Channel   Direction  Handshake                   Payload
// input     in         in_valid / in_ready         sample_in, series_start
// result    out        out_valid / out_ready       filtered_value, saturated
// config    in         APB psel/penable/pwrite     paddr, pwdata -> prdata
//
// One beat is taken per cycle unless a stalled result holds the input stage;
// a result is computed from the input stage into the result register, and the
// pace is set by the feedback through six tap multipliers into the history line.
// Reset clears the history line, the priming count and both stage valids,
// sets the order to one and all coefficients to zero.
// A stalled result holds the input stage only when that stage carries a
// sample that would give a result; priming samples always move on.
module all_pole_recursive_filter (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic signed [apf_pkg::SAMPLE_BITS-1:0] sample_in,
    input  logic                                   series_start,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic signed [apf_pkg::OUT_BITS-1:0]    filtered_value,
    output logic                                   saturated,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [apf_pkg::PADDR_BITS-1:0]         paddr,
    input  logic [apf_pkg::PDATA_BITS-1:0]         pwdata,
    output logic [apf_pkg::PDATA_BITS-1:0]         prdata,
    output logic                                   pready
);
    import apf_pkg::*;

    cfg_t cfg;

    // Input stage: the accepted beat waits here for the feedback step.
    logic                          in_v_reg;
    logic                          in_v_next;
    logic signed [SAMPLE_BITS-1:0] x_reg;
    logic                          start_reg;

    // Filter state, updated in the same cycle the result is produced.
    hist_t                 hist_reg;
    hist_t                 hist_next;
    logic [ORDER_BITS-1:0] prime_reg;
    logic [ORDER_BITS-1:0] prime_next;

    // Result stage.
    logic                  out_v_reg;
    logic                  out_v_next;
    logic [OUT_BITS-1:0]   y_reg;
    logic                  sat_reg;

    logic [ORDER_BITS-1:0] eff_order;
    logic [ORDER_BITS-1:0] prime_eff;
    logic                  priming;
    logic                  fire;
    logic                  in_take;
    logic [OUT_BITS-1:0]   mac_y;
    logic                  mac_sat;
    logic [OUT_BITS-1:0]   push_val;

    apf_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Orders above the number of taps behave as the full tap count.
    assign eff_order = (cfg.order > ORDER_BITS'(MAX_ORDER))
                     ? ORDER_BITS'(MAX_ORDER) : cfg.order;

    // A series start restarts priming from this very beat.
    assign prime_eff = start_reg ? '0 : prime_reg;
    assign priming   = prime_eff < eff_order;

    apf_mac u_mac (
        .x     (x_reg),
        .hist  (hist_reg),
        .coef  (cfg.coef),
        .order (eff_order),
        .y     (mac_y),
        .sat   (mac_sat)
    );

    // The input stage moves on when its beat primes the history or when the
    // result stage is free or being emptied in this cycle.
    assign fire     = in_v_reg && (priming || !out_v_reg || out_ready);
    assign in_ready = !in_v_reg || fire;
    assign in_take  = in_valid && in_ready;

    // Priming samples are sign-extended into the history; later beats feed
    // their own output back.
    assign push_val = priming ? OUT_BITS'(x_reg) : mac_y;

    always_comb
    begin
        hist_next  = hist_reg;
        prime_next = prime_reg;
        if (fire)
        begin
            hist_next = {hist_reg[MAX_ORDER-2:0], push_val};
            prime_next = priming ? prime_eff + ORDER_BITS'(1) : prime_eff;
        end
    end

    always_comb
    begin
        priority if (in_take)
        begin
            in_v_next = 1'b1;
        end
        else if (fire)
        begin
            in_v_next = 1'b0;
        end
        else
        begin
            in_v_next = in_v_reg;
        end
    end

    always_comb
    begin
        priority if (fire && !priming)
        begin
            out_v_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_v_next = 1'b0;
        end
        else
        begin
            out_v_next = out_v_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
            hist_reg  <= '0;
            prime_reg <= '0;
        end
        else
        begin
            in_v_reg  <= in_v_next;
            out_v_reg <= out_v_next;
            hist_reg  <= hist_next;
            prime_reg <= prime_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            x_reg     <= sample_in;
            start_reg <= series_start;
        end
        if (fire && !priming)
        begin
            y_reg   <= mac_y;
            sat_reg <= mac_sat;
        end
    end

    assign out_valid      = out_v_reg;
    assign filtered_value = y_reg;
    assign saturated      = sat_reg;

endmodule

@@ src/apf_regs.sv @@
module apf_regs (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [apf_pkg::PADDR_BITS-1:0]    paddr,
    input  logic [apf_pkg::PDATA_BITS-1:0]    pwdata,
    output logic [apf_pkg::PDATA_BITS-1:0]    prdata,
    output logic                              pready,
    output apf_pkg::cfg_t                     cfg
);
    import apf_pkg::*;

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t reg_idx;
    reg_idx_t coef_idx;
    logic     wr_en;

    assign reg_idx  = paddr[PADDR_BITS-1:2];
    assign coef_idx = reg_idx - REG_TAP_COEF_0;
    assign wr_en    = psel && penable && pwrite;
    assign pready   = 1'b1;
    assign cfg      = cfg_reg;

    // Writes to addresses past the last coefficient are dropped.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            priority if (reg_idx == REG_FILTER_ORDER)
            begin
                cfg_next.order = pwdata[ORDER_BITS-1:0];
            end
            else if (reg_idx <= REG_TAP_COEF_5)
            begin
                cfg_next.coef[coef_idx] = pwdata[COEF_BITS-1:0];
            end
            else
            begin
                cfg_next = cfg_reg;
            end
        end
    end

    always_comb
    begin
        priority if (reg_idx == REG_FILTER_ORDER)
        begin
            prdata = PDATA_BITS'(cfg_reg.order);
        end
        else if (reg_idx <= REG_TAP_COEF_5)
        begin
            prdata = PDATA_BITS'($signed(cfg_reg.coef[coef_idx]));
        end
        else
        begin
            prdata = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.order <= ORDER_BITS'(1);
            cfg_reg.coef  <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

@@ src/apf_mac.sv @@
module apf_mac (
    input  logic signed [apf_pkg::SAMPLE_BITS-1:0] x,
    input  apf_pkg::hist_t                         hist,
    input  apf_pkg::coef_arr_t                     coef,
    input  logic [apf_pkg::ORDER_BITS-1:0]         order,
    output logic [apf_pkg::OUT_BITS-1:0]           y,
    output logic                                   sat
);
    import apf_pkg::*;

    localparam int YW_BITS = ACC_BITS - FRAC_BITS;

    logic signed [PROD_BITS-1:0] prod [MAX_ORDER];
    logic signed [ACC_BITS-1:0]  acc;
    logic signed [ACC_BITS-1:0]  rnd;
    logic signed [YW_BITS-1:0]   y_wide;
    logic                        fits;

    // One multiplier per tap; taps beyond the active order contribute zero.
    for (genvar j = 0; j < MAX_ORDER; j++)
    begin : g_tap
        assign prod[j] = (order > ORDER_BITS'(j))
                       ? $signed(coef[j]) * $signed(hist[j])
                       : PROD_BITS'(0);
    end

    always_comb
    begin
        acc = {{(ACC_BITS-SAMPLE_BITS-FRAC_BITS){x[SAMPLE_BITS-1]}}, x, FRAC_BITS'(0)};
        for (int j = 0; j < MAX_ORDER; j++)
        begin
            acc = acc + ACC_BITS'(prod[j]);
        end
    end

    // Round half up, then an arithmetic shift gives the floor.
    assign rnd    = acc + (ACC_BITS'(1) <<< (FRAC_BITS - 1));
    assign y_wide = rnd[ACC_BITS-1:FRAC_BITS];
    assign fits   = (y_wide[YW_BITS-1:OUT_BITS-1] == '0)
                 || (y_wide[YW_BITS-1:OUT_BITS-1] == '1);
    assign sat    = !fits;
    assign y      = fits ? y_wide[OUT_BITS-1:0]
                  : (y_wide[YW_BITS-1] ? OUT_MIN_VAL : OUT_MAX_VAL);

endmodule

@@ src/apf_checker.sv @@
`include "all_pole_recursive_filter_assert.svh"

module apf_checker (
    input logic                                   clk,
    input logic                                   rst_n,
    input logic                                   in_ready,
    input logic                                   out_valid,
    input logic                                   out_ready,
    input logic signed [apf_pkg::OUT_BITS-1:0]    filtered_value,
    input logic                                   saturated,
    input logic                                   pready
);
    import apf_pkg::*;

    // The register port never inserts wait states.
    `APF_ASSERT_SAME(a_pready_high, 1'b1, pready, "pready dropped")

    // A result beat that is not taken stays put.
    `APF_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
        out_valid && $stable(filtered_value) && $stable(saturated),
        "stalled result beat changed")

    // A clipped result sits at one of the two limits.
    `APF_ASSERT_SAME(a_sat_limit, out_valid && saturated,
        filtered_value == OUT_MAX_VAL || filtered_value == OUT_MIN_VAL,
        "saturated result not at a limit")

    // Input backpressure only comes from a full, stalled result stage.
    `APF_ASSERT_SAME(a_ready_cause, !in_ready, out_valid && !out_ready,
        "input stalled without a stalled result")

endmodule

bind all_pole_recursive_filter apf_checker u_apf_checker (.*);
